/* design/rtnb_pkg.sv */
// ============================================================================
// rtnb_pkg
// Shared types, codes and helpers for the radix tree node builder.
// ============================================================================
`default_nettype none

package rtnb_pkg;

  localparam int COUNT_W   = 11;
  localparam int POS_W     = 10;
  localparam int IN_CODE_W = 30;
  localparam int CFG_AW    = 3;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 56;

  localparam logic       KIND_LOAD      = 1'b0;
  localparam logic       KIND_QUERY     = 1'b1;
  localparam logic       STATUS_OK      = 1'b0;
  localparam logic       STATUS_ERR     = 1'b1;
  localparam logic [0:0] REG_PRIM_COUNT = 1'b0;

  typedef logic signed [7:0] pfx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_CODE_I,
    PH_DIR_P,
    PH_DIR_M,
    PH_GROW,
    PH_BIN,
    PH_CODE_F,
    PH_CODE_L,
    PH_SPLIT
  } phase_t;

  function automatic logic [5:0] lz32(input logic [31:0] x);
    logic [31:0] v;
    logic [5:0]  c;
    v = x;
    c = 6'd0;
    if (x == 32'd0) begin
      c = 6'd32;
    end else begin
      if (v[31:16] == 16'd0) begin
        c = c + 6'd16;
        v = v << 16;
      end
      if (v[31:24] == 8'd0) begin
        c = c + 6'd8;
        v = v << 8;
      end
      if (v[31:28] == 4'd0) begin
        c = c + 6'd4;
        v = v << 4;
      end
      if (v[31:30] == 2'd0) begin
        c = c + 6'd2;
        v = v << 2;
      end
      if (v[31] == 1'b0) begin
        c = c + 6'd1;
      end
    end
    return c;
  endfunction

  function automatic pfx_t lz_pfx(input logic [31:0] x, input logic tie);
    logic [7:0] z;
    z = {2'b00, lz32(x)};
    return tie ? pfx_t'(z + 8'd32) : pfx_t'(z);
  endfunction

endpackage

`default_nettype wire

/* design/rtnb_ram.sv */
// ============================================================================
// rtnb_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
`default_nettype none

module rtnb_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* design/radix_tree_node_builder_unit.sv */
// ============================================================================
// radix_tree_node_builder_unit
// Builds one internal node of a sorted-code radix tree per query beat.
// ============================================================================
//  Channel  Dir  Handshake          Payload
//  in_      in   tvalid/tready      tuser: kind; tdata: position, code_value
//  out_     out  tvalid/tready      tuser: status; tdata: range, split, children
//  cfg_     in   APB, pready = 1    register 0 (prim_count) at byte address 0
//
// A load beat leaves the unit idle, ready for the next beat. A query beat with an
// error status goes straight to the done state. Otherwise every code probe passes
// through an issue and an evaluate state on the single read port of the code memory.
// Reset clears the control state and prim_count; the code memory is not cleared.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

module radix_tree_node_builder_unit
  import rtnb_pkg::*;
#(
  parameter int MAX_PRIMS = 1024,
  parameter int CODE_BITS = 30
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // position[9:0], code_value[39:10]
  input  wire logic              in_tuser,   // kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // range_first, range_last, split_pos,
                                             // left_child, left_is_leaf,
                                             // right_child, right_is_leaf, zero pad
  output logic                   out_tuser,  // status
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW = $clog2(MAX_PRIMS);
  localparam int SW = ((AW > POS_W) ? AW : POS_W) + 3;
  localparam logic signed [SW-1:0] MAXP_S = SW'(MAX_PRIMS);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] TWO_S  = SW'(2);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [COUNT_W-1:0]   prim_count_r;
  logic signed [SW-1:0] n_s;
  logic signed [SW-1:0] pos_s;
  logic [POS_W-1:0]     in_pos;
  logic [IN_CODE_W-1:0] in_code;
  logic                 accept;
  logic                 q_err;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CODE_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CODE_BITS-1:0] ram_rdata;

  logic signed [SW-1:0] idx_r, j_r, lmax_r, l_r, t_r, first_r, last_r, step_r, split_r;
  logic [CODE_BITS-1:0] code_i_r, fcode_r;
  logic                 oor_r, dir_r, tie_r, err_r;
  pfx_t                 dp_r, bound_r, common_r;

  logic signed [SW-1:0] j_nxt, lt_sum, step_half, l_nxt, t_nxt, fin_nxt;
  logic                 oor_nxt, dir_nxt, bin_hit, grow_hit;
  logic signed [8:0]    dir_diff;
  pfx_t                 pfx, m_val, common_nxt, bound_nxt;

  logic                 out_valid_r, status_r, left_leaf_r, right_leaf_r;
  logic [POS_W-1:0]     first_o_r, last_o_r, split_o_r, right_o_r;
  logic                 out_load;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_PRIM_COUNT) ? 32'(prim_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_PRIM_COUNT) begin
      prim_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign n_s = (SW'(prim_count_r) > MAXP_S) ? MAXP_S : SW'(prim_count_r);

  // --------------------------------------------------------------------------
  // Input side and code memory
  // --------------------------------------------------------------------------
  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_code   = in_tdata[IN_DW-1:POS_W];
  assign pos_s     = SW'(in_pos);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign q_err     = (n_s < TWO_S) || (pos_s >= n_s - ONE_S);

  assign ram_we    = accept && (in_tuser == KIND_LOAD) && (pos_s < MAXP_S);
  assign ram_waddr = pos_s[AW-1:0];
  assign ram_wdata = CODE_BITS'(in_code);
  assign ram_raddr = j_nxt[AW-1:0];

  rtnb_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (MAX_PRIMS)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Probe address
  // --------------------------------------------------------------------------
  assign lt_sum    = l_r + t_r;
  assign step_half = (step_r + ONE_S) >>> 1;

  always_comb begin
    j_nxt   = idx_r;
    oor_nxt = 1'b0;
    case (phase_r)
      PH_CODE_I: j_nxt = idx_r;
      PH_DIR_P:  j_nxt = idx_r + ONE_S;
      PH_DIR_M:  j_nxt = idx_r - ONE_S;
      PH_GROW:   j_nxt = dir_r ? idx_r + lmax_r : idx_r - lmax_r;
      PH_BIN:    j_nxt = dir_r ? idx_r + lt_sum : idx_r - lt_sum;
      PH_CODE_F: j_nxt = first_r;
      PH_CODE_L: j_nxt = last_r;
      PH_SPLIT:  j_nxt = split_r + step_half;
      default:   j_nxt = idx_r;
    endcase
    case (phase_r)
      PH_DIR_P, PH_DIR_M, PH_GROW, PH_BIN: oor_nxt = (j_nxt < 0) || (j_nxt >= n_s);
      PH_SPLIT: oor_nxt = !(j_nxt < last_r);
      default:  oor_nxt = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Probe evaluation
  // --------------------------------------------------------------------------
  always_comb begin
    pfx = oor_r ? -8'sd1
        : lz_pfx((code_i_r == ram_rdata) ? 32'(idx_r[AW-1:0] ^ j_r[AW-1:0])
                                         : 32'(code_i_r ^ ram_rdata),
                 code_i_r == ram_rdata);
    m_val = lz_pfx(tie_r ? 32'(first_r[AW-1:0] ^ j_r[AW-1:0])
                         : 32'(fcode_r ^ ram_rdata), tie_r);
    common_nxt = lz_pfx((fcode_r == ram_rdata) ? 32'(first_r[AW-1:0] ^ last_r[AW-1:0])
                                               : 32'(fcode_r ^ ram_rdata),
                        fcode_r == ram_rdata);
    dir_diff  = {dp_r[7], dp_r} - {pfx[7], pfx};
    dir_nxt   = (dir_diff > 9'sd0);
    bound_nxt = dir_nxt ? pfx : dp_r;
    grow_hit  = (pfx > bound_r);
    bin_hit   = (pfx > bound_r);
    l_nxt     = bin_hit ? lt_sum : l_r;
    t_nxt     = t_r >>> 1;
    fin_nxt   = dir_r ? idx_r + l_nxt : idx_r - l_nxt;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser == KIND_QUERY) begin
          phase_nxt = PH_CODE_I;
          state_nxt = q_err ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_EVAL;
      ST_EVAL: begin
        state_nxt = ST_ISSUE;
        case (phase_r)
          PH_CODE_I: phase_nxt = PH_DIR_P;
          PH_DIR_P:  phase_nxt = PH_DIR_M;
          PH_DIR_M:  phase_nxt = PH_GROW;
          PH_GROW:   phase_nxt = grow_hit ? PH_GROW : PH_BIN;
          PH_BIN:    phase_nxt = (t_nxt == 0) ? PH_CODE_F : PH_BIN;
          PH_CODE_F: phase_nxt = PH_CODE_L;
          PH_CODE_L: phase_nxt = PH_SPLIT;
          PH_SPLIT:  state_nxt = (step_r > ONE_S) ? ST_ISSUE : ST_DONE;
          default:   phase_nxt = PH_CODE_I;
        endcase
      end
      ST_DONE: state_nxt = out_load ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_CODE_I;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      idx_r <= pos_s;
      err_r <= q_err;
    end
    if (state_r == ST_ISSUE) begin
      j_r   <= j_nxt;
      oor_r <= oor_nxt;
      if (phase_r == PH_SPLIT) begin
        step_r <= step_half;
      end
    end
    if (state_r == ST_EVAL) begin
      case (phase_r)
        PH_CODE_I: code_i_r <= ram_rdata;
        PH_DIR_P:  dp_r <= pfx;
        PH_DIR_M: begin
          dir_r   <= dir_nxt;
          bound_r <= bound_nxt;
          lmax_r  <= TWO_S;
        end
        PH_GROW: begin
          if (grow_hit) begin
            lmax_r <= lmax_r <<< 1;
          end else begin
            t_r <= lmax_r >>> 1;
            l_r <= '0;
          end
        end
        PH_BIN: begin
          l_r <= l_nxt;
          t_r <= t_nxt;
          if (t_nxt == 0) begin
            first_r <= dir_r ? idx_r : fin_nxt;
            last_r  <= dir_r ? fin_nxt : idx_r;
          end
        end
        PH_CODE_F: fcode_r <= ram_rdata;
        PH_CODE_L: begin
          tie_r    <= (fcode_r == ram_rdata);
          common_r <= common_nxt;
          step_r   <= last_r - first_r;
          split_r  <= first_r;
        end
        PH_SPLIT: begin
          if (!oor_r && m_val > common_r) begin
            split_r <= j_r;
          end
        end
        default: code_i_r <= code_i_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err_r) begin
        status_r     <= STATUS_ERR;
        first_o_r    <= '0;
        last_o_r     <= '0;
        split_o_r    <= '0;
        right_o_r    <= '0;
        left_leaf_r  <= 1'b0;
        right_leaf_r <= 1'b0;
      end else begin
        status_r     <= STATUS_OK;
        first_o_r    <= first_r[POS_W-1:0];
        last_o_r     <= last_r[POS_W-1:0];
        split_o_r    <= split_r[POS_W-1:0];
        right_o_r    <= split_r[POS_W-1:0] + POS_W'(1);
        left_leaf_r  <= (split_r == first_r);
        right_leaf_r <= (split_r + ONE_S == last_r);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {4'b0000, right_leaf_r, right_o_r, left_leaf_r, split_o_r,
                       split_o_r, last_o_r, first_o_r};

endmodule

`default_nettype wire
